### rtl/core/obb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_pkg
// Shared constants for the orthonormal basis builder core.
// ----------------------------------------------------------------------------
package obb_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int IN_FRAC    = 16;
    localparam int MUL_CHUNK  = 24;

endpackage

### rtl/core/obb_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_mul
// Pipelined signed multiplier built from chunk products, summed row by row.
// The pipeline advances only while ce is high.
// ----------------------------------------------------------------------------
module obb_mul #(
    parameter int AW    = obb_pkg::DATA_WIDTH,
    parameter int BW    = obb_pkg::DATA_WIDTH,
    parameter int CHUNK = obb_pkg::MUL_CHUNK
) (
    input  logic                 aclk,
    input  logic                 ce,
    input  logic [AW-1:0]        a,
    input  logic [BW-1:0]        b,
    output logic [AW+BW-1:0]     p
);

    localparam int NA  = (AW + CHUNK - 1) / CHUNK;
    localparam int NB  = (BW + CHUNK - 1) / CHUNK;
    localparam int PRW = (NA + NB) * CHUNK;

    logic [AW-1:0]         abs_a;
    logic [BW-1:0]         abs_b;
    logic [NA*CHUNK-1:0]   ma_reg;
    logic [NB*CHUNK-1:0]   mb_reg;
    logic [2*CHUNK-1:0]    prod_reg [NA][NB];
    logic [PRW-1:0]        row_e [NA];
    logic [PRW-1:0]        row_o [NA];
    logic [PRW-1:0]        rd_reg [NA][NA];
    logic                  neg_reg [NA+2];

    always_comb begin
        abs_a = a[AW-1] ? AW'(-$signed(a)) : a;
        abs_b = b[BW-1] ? BW'(-$signed(b)) : b;
    end

    // rows of chunk products, even and odd columns never overlap
    always_comb begin
        for (int m = 0; m < NA; m++) begin
            row_e[m] = '0;
            row_o[m] = '0;
            for (int j = 0; j < NB; j++) begin
                if (j % 2 == 0) begin
                    row_e[m][(m+j)*CHUNK +: 2*CHUNK] = prod_reg[m][j];
                end else begin
                    row_o[m][(m+j)*CHUNK +: 2*CHUNK] = prod_reg[m][j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ma_reg     <= (NA*CHUNK)'(abs_a);
            mb_reg     <= (NB*CHUNK)'(abs_b);
            neg_reg[0] <= a[AW-1] ^ b[BW-1];
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    prod_reg[i][j] <= ma_reg[i*CHUNK +: CHUNK] * mb_reg[j*CHUNK +: CHUNK];
                end
            end
            for (int k = 1; k < NA + 2; k++) begin
                neg_reg[k] <= neg_reg[k-1];
            end
            for (int m = 0; m < NA; m++) begin
                rd_reg[0][m] <= row_e[m] + row_o[m];
            end
            for (int k = 1; k < NA; k++) begin
                rd_reg[k][0] <= rd_reg[k-1][0] + rd_reg[k-1][k];
                for (int m = 1; m < NA; m++) begin
                    rd_reg[k][m] <= rd_reg[k-1][m];
                end
            end
            p <= (AW+BW)'(neg_reg[NA+1] ? -rd_reg[NA-1][0] : rd_reg[NA-1][0]);
        end
    end

endmodule

### rtl/core/orthonormal_basis_builder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orthonormal_basis_builder_core
// Two unit vectors perpendicular to a Q16.16 input vector, in Q2.30.
// ----------------------------------------------------------------------------
// widths: CW = 3*W + 2 for W >= 18, W = DATA_WIDTH
// throughput: one beat per cycle, every stage pipelined; input stalls only
// in reset or while the skid entry holds a beat that the output has not yet taken
// reset: clears the valid bits of all stages and of the output and skid registers
// ----------------------------------------------------------------------------
module orthonormal_basis_builder_core #(
    parameter int DATA_WIDTH = obb_pkg::DATA_WIDTH
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // vec_x, vec_y, vec_z
    input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    output logic [((6*DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
    // degenerate
    output logic                                     m_axis_tuser
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = W - 2;
    localparam int IFR = obb_pkg::IN_FRAC;
    localparam int K   = obb_pkg::MUL_CHUNK;
    localparam int HW  = (W > IFR + 2) ? W : IFR + 2;
    localparam int UW  = W + HW + 1;
    localparam int CW  = W + UW + 1;
    localparam int LM  = (W + K - 1) / K + 3;
    localparam int LS  = (CW + K - 1) / K + 3;
    localparam int QB  = W;
    localparam int SW  = 2 * CW;
    localparam int PW  = SW + QB;
    localparam int RW  = SW + 2 * QB + 1;
    localparam int DN  = LM + 1;
    localparam int DS  = LS;
    localparam int PU  = 1 + LM + 1;
    localparam int PV  = PU + LM + 1;
    localparam int PS  = PV + LS + 1;
    localparam int PF  = PS + QB + 1;
    localparam int NV  = PF + 1;
    localparam int ODW = ((6*W+7)/8)*8;
    localparam int CROSS_A [6] = '{1, 2, 2, 0, 0, 1};
    localparam int CROSS_B [6] = '{2, 1, 0, 2, 1, 0};

    logic                 ce;
    logic                 vld_reg [NV];
    logic [2:0][W-1:0]    n0_reg;
    logic [2:0][W-1:0]    n1_reg;
    logic [2:0][HW-1:0]   h1_reg;
    logic [2:0][HW-1:0]   h1_next;
    logic [W-1:0]         mag [3];
    logic [2:0][W-1:0]    nd_reg [DN];
    logic [W+HW-1:0]      pu [6];
    logic [2:0][UW-1:0]   u_reg;
    logic [2:0][UW-1:0]   ud_reg [DN];
    logic [W+UW-1:0]      pv [6];
    logic [2:0][CW-1:0]   v_reg;
    logic [CW-1:0]        cv [6];
    logic [2*CW-1:0]      sq [6];
    logic                 sd_reg [DS][6];
    logic [RW-1:0]        rr_reg [6][QB+1];
    logic [PW-1:0]        pp_reg [6][QB+1];
    logic [QB-1:0]        qq_reg [6][QB+1];
    logic [SW-1:0]        ss_reg [2][QB+1];
    logic                 zz_reg [2][QB+1];
    logic                 sg_reg [6][QB+1];
    logic [RW:0]          dif [6][QB];
    logic [QB:0]          rnd [6];
    logic [W-1:0]         fo_next [6];
    logic [5:0][W-1:0]    fo_reg;
    logic                 fdeg_reg;
    logic [6*W-1:0]       m_data_reg;
    logic                 m_user_reg;
    logic                 m_valid_reg;
    logic [6*W-1:0]       sk_data_reg;
    logic                 sk_user_reg;
    logic                 sk_valid_reg;
    logic                 take;

    assign ce            = !sk_valid_reg;
    assign s_axis_tready = ce && aresetn;
    assign take          = m_valid_reg && m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = ODW'(m_data_reg);
    assign m_axis_tuser  = m_user_reg;

    // helper vector: smallest magnitude component replaced by one
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i]     = n0_reg[i][W-1] ? W'(-$signed(n0_reg[i])) : n0_reg[i];
            h1_next[i] = HW'($signed(n0_reg[i]));
        end
        if (mag[0] <= mag[1] && mag[0] <= mag[2]) begin
            h1_next[0] = HW'(1) << IFR;
        end else if (mag[1] <= mag[0] && mag[1] <= mag[2]) begin
            h1_next[1] = HW'(1) << IFR;
        end else begin
            h1_next[2] = HW'(1) << IFR;
        end
    end

    for (genvar k = 0; k < 6; k++) begin : g_mul
        obb_mul #(.AW(W), .BW(HW), .CHUNK(K)) u_mul_u (
            .aclk (aclk),
            .ce   (ce),
            .a    (n1_reg[CROSS_A[k]]),
            .b    (h1_reg[CROSS_B[k]]),
            .p    (pu[k])
        );
        obb_mul #(.AW(W), .BW(UW), .CHUNK(K)) u_mul_v (
            .aclk (aclk),
            .ce   (ce),
            .a    (nd_reg[DN-1][CROSS_A[k]]),
            .b    (u_reg[CROSS_B[k]]),
            .p    (pv[k])
        );
        assign cv[k] = (k < 3) ? CW'($signed(ud_reg[DN-1][k % 3])) : v_reg[k % 3];
        obb_mul #(.AW(CW), .BW(CW), .CHUNK(K)) u_mul_sq (
            .aclk (aclk),
            .ce   (ce),
            .a    (cv[k]),
            .b    (cv[k]),
            .p    (sq[k])
        );
    end

    // one quotient-root bit per stage: keep q*q*s <= 4*c*c*2^(2F)
    always_comb begin
        for (int c = 0; c < 6; c++) begin
            for (int k = 0; k < QB; k++) begin
                dif[c][k] = {1'b0, rr_reg[c][k]}
                          - ((RW+1)'(pp_reg[c][k]) << (QB - k))
                          - ((RW+1)'(ss_reg[c/3][k]) << (2 * (QB - 1 - k)));
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 6; c++) begin
            rnd[c] = (QB+1)'(qq_reg[c][QB]) + (QB+1)'(1);
            if (zz_reg[c/3][QB]) begin
                fo_next[c] = '0;
            end else if (sg_reg[c][QB]) begin
                fo_next[c] = W'(-rnd[c][QB:1]);
            end else begin
                fo_next[c] = W'(rnd[c][QB:1]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NV; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (ce) begin
            vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < NV; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                n0_reg[i] <= s_axis_tdata[i*W +: W];
            end
            n1_reg    <= n0_reg;
            h1_reg    <= h1_next;
            nd_reg[0] <= n1_reg;
            ud_reg[0] <= u_reg;
            for (int d = 1; d < DN; d++) begin
                nd_reg[d] <= nd_reg[d-1];
                ud_reg[d] <= ud_reg[d-1];
            end
            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= UW'($signed(pu[2*i])) - UW'($signed(pu[2*i+1]));
                v_reg[i] <= CW'($signed(pv[2*i])) - CW'($signed(pv[2*i+1]));
            end
            for (int c = 0; c < 6; c++) begin
                sd_reg[0][c] <= cv[c][CW-1];
                for (int d = 1; d < DS; d++) begin
                    sd_reg[d][c] <= sd_reg[d-1][c];
                end
                rr_reg[c][0] <= RW'(sq[c][SW-1:0]) << (2 * F + 2);
                pp_reg[c][0] <= '0;
                qq_reg[c][0] <= '0;
                sg_reg[c][0] <= sd_reg[DS-1][c];
                for (int k = 0; k < QB; k++) begin
                    sg_reg[c][k+1] <= sg_reg[c][k];
                    if (!dif[c][k][RW]) begin
                        rr_reg[c][k+1] <= dif[c][k][RW-1:0];
                        pp_reg[c][k+1] <= pp_reg[c][k]
                                        + (PW'(ss_reg[c/3][k]) << (QB - 1 - k));
                        qq_reg[c][k+1] <= qq_reg[c][k] | (QB'(1) << (QB - 1 - k));
                    end else begin
                        rr_reg[c][k+1] <= rr_reg[c][k];
                        pp_reg[c][k+1] <= pp_reg[c][k];
                        qq_reg[c][k+1] <= qq_reg[c][k];
                    end
                end
            end
            for (int g = 0; g < 2; g++) begin
                ss_reg[g][0] <= sq[3*g][SW-1:0] + sq[3*g+1][SW-1:0] + sq[3*g+2][SW-1:0];
                zz_reg[g][0] <= (sq[3*g] | sq[3*g+1] | sq[3*g+2]) == '0;
                for (int k = 0; k < QB; k++) begin
                    ss_reg[g][k+1] <= ss_reg[g][k];
                    zz_reg[g][k+1] <= zz_reg[g][k];
                end
            end
            for (int c = 0; c < 6; c++) begin
                fo_reg[c] <= fo_next[c];
            end
            fdeg_reg <= zz_reg[0][QB] || zz_reg[1][QB];
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            sk_valid_reg <= 1'b0;
        end else if (sk_valid_reg) begin
            if (take) begin
                sk_valid_reg <= 1'b0;
            end
        end else if (vld_reg[PF]) begin
            if (!m_valid_reg || take) begin
                m_valid_reg <= 1'b1;
            end else begin
                sk_valid_reg <= 1'b1;
            end
        end else if (take) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (sk_valid_reg) begin
            if (take) begin
                m_data_reg <= sk_data_reg;
                m_user_reg <= sk_user_reg;
            end
        end else if (vld_reg[PF]) begin
            if (!m_valid_reg || take) begin
                m_data_reg <= fo_reg;
                m_user_reg <= fdeg_reg;
            end else begin
                sk_data_reg <= fo_reg;
                sk_user_reg <= fdeg_reg;
            end
        end
    end

endmodule
